@@ hw/rtl/dual_token_bucket_limiter_macros.svh @@
// Assertion helpers for the limiter
`ifndef DUAL_TOKEN_BUCKET_LIMITER_MACROS_SVH
`define DUAL_TOKEN_BUCKET_LIMITER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define DTBL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define DTBL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/dtbl_pkg.sv @@
package dtbl_pkg;

	localparam int REQ_W      = 24;
	localparam int RATE_W     = 32;
	localparam int WAIT_W     = 35;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;

	localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_REQ  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_RATE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CONN_RATE   = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [REQ_W-1:0] request_bytes;
	} item_t;

	typedef struct packed {
		logic              granted;
		logic [WAIT_W-1:0] wait_ticks;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic tick;
		logic eval;
		logic div_step;
		logic round;
		logic out_load;
	} dtbl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic grant;
	} dtbl_stat_t;

	typedef struct packed {
		logic start;
		logic step;
		logic round;
	} div_cmd_t;

endpackage

@@ hw/rtl/dual_token_bucket_limiter.sv @@
// Tick beat: buckets update at the edge that takes it, no result.
// Request granted at once or from the buckets: result registers via S_EVAL and S_DONE.
// Refused request: result registers via S_EVAL, S_DIV, S_RND and S_DONE; the wait
// comes from a restoring divider that retires one quotient bit per cycle.
// One request at a time; the next beat is taken the cycle after the result registers.
// Reset clears both rates and both buckets, so every request is granted.
`include "dual_token_bucket_limiter_macros.svh"

module dual_token_bucket_limiter #(
	parameter int FRACTION_BITS = 10,
	parameter int REQUEST_BITS  = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [dtbl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dtbl_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  dtbl_pkg::item_t                 item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output dtbl_pkg::result_t               result
);
	import dtbl_pkg::*;

	dtbl_cmd_t  cmd;
	dtbl_stat_t stat;

	dtbl_ctrl #(.FRACTION_BITS(FRACTION_BITS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_cmd     (item.cmd),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd),
		.stat         (stat)
	);

	dtbl_dp #(
		.FRACTION_BITS (FRACTION_BITS),
		.REQUEST_BITS  (REQUEST_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

	`DTBL_ASSERT_NOW(a_grant_no_wait, clk, arst_n, result_valid && result.granted, result.wait_ticks == '0, "granted result carries a wait")
	`DTBL_ASSERT_NEXT(a_req_busy, clk, arst_n, item_valid && !item_stall && (item.cmd == CMD_REQ), item_stall, "request beat did not block intake")
	`DTBL_ASSERT_NEXT(a_tick_silent, clk, arst_n, item_valid && !item_stall && (item.cmd == CMD_TICK) && !result_valid, !result_valid, "tick beat produced a result")

endmodule

@@ hw/rtl/dtbl_div.sv @@
module dtbl_div #(
	parameter int DW = 34,
	parameter int VW = 32
) (
	input  logic              clk,
	input  dtbl_pkg::div_cmd_t cmd,
	input  logic [DW-1:0]     dividend,
	input  logic [VW-1:0]     divisor,
	output logic [DW:0]       quot_ceil
);
	import dtbl_pkg::*;

	logic [DW-1:0] dvd_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dsr_q;
	logic          zero_q;
	logic [DW:0]   res_q;

	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	// restoring division, one quotient bit per step; quotient shifts into dvd_q
	assign trial = {rem_q, dvd_q[DW-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			dvd_q  <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
			zero_q <= (divisor == '0) || (dividend == '0);
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[DW-2:0], ge};
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
		end
		// round up when a remainder is left
		if (cmd.round) begin
			res_q <= zero_q ? '0 : ({1'b0, dvd_q} + {{DW{1'b0}}, (rem_q != '0)});
		end
	end

	assign quot_ceil = res_q;

endmodule

@@ hw/rtl/dtbl_dp.sv @@
module dtbl_dp #(
	parameter int FRACTION_BITS = 10,
	parameter int REQUEST_BITS  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [dtbl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtbl_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  dtbl_pkg::item_t                     item,
	input  dtbl_pkg::dtbl_cmd_t                 cmd,
	output dtbl_pkg::dtbl_stat_t                stat,
	output dtbl_pkg::result_t                   result
);
	import dtbl_pkg::*;

	localparam int TW = RATE_W + FRACTION_BITS;
	localparam int MW = REQ_W + FRACTION_BITS;
	localparam int RB = (REQUEST_BITS < REQ_W) ? REQUEST_BITS : REQ_W;
	localparam int XW = (MW + 1 > WAIT_W) ? MW + 1 : WAIT_W;
	localparam logic [REQ_W-1:0] BYTE_MASK = REQ_W'((64'd1 << RB) - 64'd1);

	logic [RATE_W-1:0] grate_q, crate_q;
	logic [TW-1:0]     gtok_q, ctok_q;
	logic [REQ_W-1:0]  bytes_q;
	logic              grant_q;
	result_t           res_q;

	logic [RATE_W-1:0] grate_nx, crate_nx;
	logic [TW-1:0]     gcap, ccap;
	logic [TW:0]       gsum, csum;
	logic [TW-1:0]     gtick, ctick;
	logic [MW-1:0]     need;
	logic [TW-1:0]     need_t;
	logic [TW-1:0]     gshort, cshort;
	logic              quick, ok;
	div_cmd_t          dcmd;
	logic [MW:0]       wg, wc, wmax;
	logic [XW-1:0]     wx;
	logic [WAIT_W-1:0] wsat;

	always_comb begin
		grate_nx = grate_q;
		crate_nx = crate_q;
		unique case (cfg_index)
			REG_GLOBAL_RATE: grate_nx = cfg_data;
			REG_CONN_RATE:   crate_nx = cfg_data;
			default: ;
		endcase
	end

	assign gcap  = TW'(grate_q) << FRACTION_BITS;
	assign ccap  = TW'(crate_q) << FRACTION_BITS;
	assign gsum  = {1'b0, gtok_q} + (TW+1)'(grate_q);
	assign csum  = {1'b0, ctok_q} + (TW+1)'(crate_q);
	assign gtick = (grate_q == '0) ? '0 : ((gsum > {1'b0, gcap}) ? gcap : gsum[TW-1:0]);
	assign ctick = (crate_q == '0) ? '0 : ((csum > {1'b0, ccap}) ? ccap : csum[TW-1:0]);

	assign need   = MW'(bytes_q) << FRACTION_BITS;
	assign need_t = TW'(need);
	assign gshort = ((grate_q != '0) && (need_t > gtok_q)) ? (need_t - gtok_q) : '0;
	assign cshort = ((crate_q != '0) && (need_t > ctok_q)) ? (need_t - ctok_q) : '0;
	assign quick  = (bytes_q == '0) || ((grate_q == '0) && (crate_q == '0));
	assign ok     = (gshort == '0) && (cshort == '0);

	assign stat.grant = quick || ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grate_q <= '0;
			crate_q <= '0;
			gtok_q  <= '0;
			ctok_q  <= '0;
		end else if (cfg_wr_en) begin
			// new rate refills both buckets to capacity
			grate_q <= grate_nx;
			crate_q <= crate_nx;
			gtok_q  <= TW'(grate_nx) << FRACTION_BITS;
			ctok_q  <= TW'(crate_nx) << FRACTION_BITS;
		end else if (cmd.tick) begin
			gtok_q <= gtick;
			ctok_q <= ctick;
		end else if (cmd.eval && ok && !quick) begin
			if (grate_q != '0) gtok_q <= gtok_q - need_t;
			if (crate_q != '0) ctok_q <= ctok_q - need_t;
		end
	end

	assign dcmd.start = cmd.eval;
	assign dcmd.step  = cmd.div_step;
	assign dcmd.round = cmd.round;

	dtbl_div #(.DW(MW), .VW(RATE_W)) u_div_g (
		.clk       (clk),
		.cmd       (dcmd),
		.dividend  (gshort[MW-1:0]),
		.divisor   (grate_q),
		.quot_ceil (wg)
	);

	dtbl_div #(.DW(MW), .VW(RATE_W)) u_div_c (
		.clk       (clk),
		.cmd       (dcmd),
		.dividend  (cshort[MW-1:0]),
		.divisor   (crate_q),
		.quot_ceil (wc)
	);

	assign wmax = (wg > wc) ? wg : wc;
	assign wx   = XW'(wmax);
	assign wsat = (wx > XW'(WAIT_MAX)) ? WAIT_MAX : wx[WAIT_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) bytes_q <= item.request_bytes & BYTE_MASK;
		if (cmd.eval) grant_q <= quick || ok;
		if (cmd.out_load) begin
			res_q.granted    <= grant_q;
			res_q.wait_ticks <= grant_q ? '0 : wsat;
		end
	end

	assign result = res_q;

endmodule

@@ hw/rtl/dtbl_ctrl.sv @@
module dtbl_ctrl #(
	parameter int FRACTION_BITS = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic                 item_cmd,
	output logic                 item_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	output dtbl_pkg::dtbl_cmd_t  cmd,
	input  dtbl_pkg::dtbl_stat_t stat
);
	import dtbl_pkg::*;

	localparam int MW = REQ_W + FRACTION_BITS;
	localparam int CW = $clog2(MW);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_EVAL = 5'b00010,
		S_DIV  = 5'b00100,
		S_RND  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t        state_q, state_nx;
	logic [CW-1:0] cnt_q, cnt_nx;
	logic          oval_q;
	logic          accept;
	logic          slot_free;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign slot_free  = !oval_q || !result_stall;

	always_comb begin
		state_nx = state_q;
		cnt_nx   = cnt_q;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = accept;
				cmd.tick = accept && (item_cmd == CMD_TICK);
				if (accept && (item_cmd == CMD_REQ)) state_nx = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				cnt_nx   = '0;
				state_nx = stat.grant ? S_DONE : S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CW'(MW - 1)) begin
					state_nx = S_RND;
				end else begin
					cnt_nx = cnt_q + 1'b1;
				end
			end
			S_RND: begin
				cmd.round = 1'b1;
				state_nx  = S_DONE;
			end
			S_DONE: begin
				// hold until the output register frees up
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			oval_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			cnt_q   <= cnt_nx;
			if (cmd.out_load) oval_q <= 1'b1;
			else if (!result_stall) oval_q <= 1'b0;
		end
	end

	assign result_valid = oval_q;

endmodule
